@@ rtl/tpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tpsp_pkg
// Shared types, codes and the sine table generator for the two-phase
// open-loop sine commutator.
// ----------------------------------------------------------------------------
package tpsp_pkg;

    // default size of the quarter-wave sine table, a power of two
    localparam int unsigned SINE_ROM_DEPTH_DEF = 256;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // request codes
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_SET_ANGLE = 2'd1;
    localparam logic [1:0] REQ_RAMP      = 2'd2;
    localparam logic [1:0] REQ_SET_RATIO = 2'd3;

    // phase drive codes
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_FWD = 2'd1;
    localparam logic [1:0] MODE_REV = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_CAP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_A   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_B   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUPPLY_OK  = 3'd5;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] PHASE_STEP_RST = 16'd0;
    localparam logic [14:0] DUTY_CAP_RST   = 15'd29491;
    localparam logic [14:0] DEADBAND_RST   = 15'd0;
    localparam logic [15:0] PERIOD_RST     = 16'd65535;

    // input word
    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        angle;
        logic signed [15:0] amplitude;
        logic [14:0]        amp_goal;
        logic [14:0]        ramp_step;
    } req_word_t;

    // result word
    typedef struct packed {
        logic [1:0]  mode_a;
        logic [15:0] duty_a;
        logic [1:0]  mode_b;
        logic [15:0] duty_b;
        logic [15:0] angle_now;
    } rsp_word_t;

    // per-phase drive decision
    typedef struct packed {
        logic [1:0]  mode;
        logic [14:0] ratio;
    } drive_t;

    // series term divisor 2k(2k+1)
    function automatic logic [63:0] series_div(input logic [63:0] term, input int unsigned k);
        logic [63:0] res;
        case (k)
            1:       res = term / 64'd6;
            2:       res = term / 64'd20;
            3:       res = term / 64'd42;
            4:       res = term / 64'd72;
            5:       res = term / 64'd110;
            6:       res = term / 64'd156;
            7:       res = term / 64'd210;
            8:       res = term / 64'd272;
            9:       res = term / 64'd342;
            default: res = term / 64'd420;
        endcase
        return res;
    endfunction

    // table entry i of a quarter wave with 2**shift steps, 32767 full scale
    function automatic logic [14:0] sine_entry(input int unsigned i, input int unsigned shift);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        x    = (HALF_PI_Q30 * 64'(i)) >> shift;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int unsigned k = 1; k <= 10; k++)
        begin
            term = series_div((term * x2) >> 30, k);
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        scaled = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        return scaled[14:0];
    endfunction

endpackage

@@ rtl/two_phase_open_loop_sine_pwm.sv @@
// ----------------------------------------------------------------------------
// two_phase_open_loop_sine_pwm
// Open-loop sine commutator for a two-phase motor: keeps angle and amplitude,
// produces per-phase drive mode and PWM compare values.
// Tick and set-angle words: a 6-step sequencer over one sine ROM read port
// and one shared multiplier registers the result word in its last step, and
// no new word is taken until the sequencer is back in idle;
// a stalled result word holds the sequencer in its last step.
// Ramp and set-ratio words: no result, and the block stays idle.
// Reset (rst_n low, async): angle 0, amplitude 0, registers to defaults.
// ----------------------------------------------------------------------------
module two_phase_open_loop_sine_pwm #(
    parameter int unsigned SINE_ROM_DEPTH = tpsp_pkg::SINE_ROM_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  tpsp_pkg::req_word_t                    req_word,
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output tpsp_pkg::rsp_word_t                    rsp_word,
    input  logic                                   cfg_we,
    input  logic [tpsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [tpsp_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import tpsp_pkg::*;

    // table depth must be a power of two
    localparam int unsigned AW    = $clog2(SINE_ROM_DEPTH);
    localparam int unsigned IDX_W = AW + 2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SIN  = 7'b0000010,
        S_COS  = 7'b0000100,
        S_MULB = 7'b0001000,
        S_DA   = 7'b0010000,
        S_DB   = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        phase_reg, phase_next;
    logic signed [15:0] amp_reg, amp_next;

    logic [15:0]        phase_step_reg;
    logic [14:0]        duty_cap_reg;
    logic [14:0]        deadband_reg;
    logic [15:0]        period_a_reg;
    logic [15:0]        period_b_reg;
    logic               supply_ok_reg;

    drive_t             drv_a_reg, drv_b_reg;
    logic [15:0]        duty_a_reg;
    logic               rsp_valid_reg;
    rsp_word_t          rsp_word_reg;

    logic               accept;
    logic               rsp_load;
    logic [IDX_W-1:0]   rom_idx;
    logic signed [15:0] rom_data;
    logic               mul_en;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod;
    drive_t             drv;
    logic [15:0]        cnt;
    logic [15:0]        period_sel;
    logic [15:0]        duty_sat;
    logic [14:0]        target;
    logic signed [17:0] cur, tgt, up, dn, ramp_val;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            duty_cap_reg   <= DUTY_CAP_RST;
            deadband_reg   <= DEADBAND_RST;
            period_a_reg   <= PERIOD_RST;
            period_b_reg   <= PERIOD_RST;
            supply_ok_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                CFG_DUTY_CAP:   duty_cap_reg   <= cfg_data[14:0];
                CFG_DEADBAND:   deadband_reg   <= cfg_data[14:0];
                CFG_PERIOD_A:   period_a_reg   <= cfg_data;
                CFG_PERIOD_B:   period_b_reg   <= cfg_data;
                CFG_SUPPLY_OK:  supply_ok_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    // ramp step toward the clamped target
    assign target = (req_word.amp_goal > duty_cap_reg) ? duty_cap_reg
                                                       : req_word.amp_goal;
    assign cur = supply_ok_reg ? 18'(amp_reg) : 18'sd0;
    assign tgt = $signed({3'b000, target});
    assign up  = cur + $signed({3'b000, req_word.ramp_step});
    assign dn  = cur - $signed({3'b000, req_word.ramp_step});

    always_comb
    begin
        if (cur < tgt)
            ramp_val = (up > tgt) ? tgt : up;
        else if (cur > tgt)
            ramp_val = (dn < tgt) ? tgt : dn;
        else
            ramp_val = cur;
    end

    // angle and amplitude update on an accepted word
    always_comb
    begin
        phase_next = phase_reg;
        amp_next   = amp_reg;
        if (accept)
        begin
            case (req_word.req_type)
                REQ_TICK:      phase_next = phase_reg + phase_step_reg;
                REQ_SET_ANGLE:
                begin
                    phase_next = req_word.angle;
                    amp_next   = req_word.amplitude;
                end
                REQ_RAMP:      amp_next = ramp_val[15:0];
                REQ_SET_RATIO: amp_next = $signed({1'b0, target});
                default:       ;
            endcase
        end
    end

    // sequencer
    assign rsp_load = (state_reg == S_FIN) && !(rsp_valid_reg && rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_word.req_type == REQ_TICK
                               || req_word.req_type == REQ_SET_ANGLE))
                    state_next = S_SIN;
            end
            S_SIN:   state_next = S_COS;
            S_COS:   state_next = S_MULB;
            S_MULB:  state_next = S_DA;
            S_DA:    state_next = S_DB;
            S_DB:    state_next = S_FIN;
            S_FIN:
            begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 16'd0;
            amp_reg   <= 16'sd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            amp_reg   <= amp_next;
        end
    end

    // sine read, then cosine a quarter turn later
    assign rom_idx = phase_reg[15 -: IDX_W]
                     + ((state_reg == S_COS) ? IDX_W'(SINE_ROM_DEPTH) : IDX_W'(0));

    tpsp_sine_rom #(
        .DEPTH (SINE_ROM_DEPTH)
    ) u_rom (
        .clk  (clk),
        .idx  (rom_idx),
        .data (rom_data)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = $signed({rom_data[15], rom_data});
        mul_b  = $signed({amp_reg[15], amp_reg});
        case (state_reg)
            S_COS, S_MULB: ;
            S_DA:
            begin
                mul_a = $signed({2'b00, drv_a_reg.ratio});
                mul_b = $signed({1'b0, period_a_reg});
            end
            S_DB:
            begin
                mul_a = $signed({2'b00, drv_b_reg.ratio});
                mul_b = $signed({1'b0, period_b_reg});
            end
            default: mul_en = 1'b0;
        endcase
    end

    tpsp_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // alpha is the negated sine product
    tpsp_phase_drive u_drive (
        .prod      (prod),
        .negate    (state_reg == S_MULB),
        .supply_ok (supply_ok_reg),
        .duty_cap  (duty_cap_reg),
        .deadband  (deadband_reg),
        .drive     (drv)
    );

    // compare value, saturated to the period
    assign period_sel = (state_reg == S_DB) ? period_a_reg : period_b_reg;
    assign cnt        = prod[30:15];
    assign duty_sat   = (cnt > period_sel) ? period_sel : cnt;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MULB)
            drv_a_reg <= drv;
        if (state_reg == S_DA)
            drv_b_reg <= drv;
        if (state_reg == S_DB)
            duty_a_reg <= duty_sat;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_word_reg.mode_a    <= drv_a_reg.mode;
            rsp_word_reg.duty_a    <= duty_a_reg;
            rsp_word_reg.mode_b    <= drv_b_reg.mode;
            rsp_word_reg.duty_b    <= duty_sat;
            rsp_word_reg.angle_now <= phase_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // a drive request starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_word.req_type == REQ_TICK || req_word.req_type == REQ_SET_ANGLE))
        |=> state_reg == S_SIN)
    else $error("drive request did not start the sequencer");

    // amplitude-only requests finish at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_word.req_type == REQ_RAMP || req_word.req_type == REQ_SET_RATIO))
        |=> state_reg == S_IDLE)
    else $error("amplitude request left the block busy");

    // an off phase carries no duty
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_word_reg.mode_a != MODE_OFF || rsp_word_reg.duty_a == 16'd0)
                           && (rsp_word_reg.mode_b != MODE_OFF
                               || rsp_word_reg.duty_b == 16'd0)))
    else $error("off phase with nonzero duty");

    // compare values never exceed the periods
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_word_reg.duty_a <= period_a_reg
                           && rsp_word_reg.duty_b <= period_b_reg))
    else $error("compare value above period");

endmodule

@@ rtl/tpsp_sine_rom.sv @@
// ----------------------------------------------------------------------------
// tpsp_sine_rom
// Quarter-wave sine table with quadrant folding and a registered read.
// ----------------------------------------------------------------------------
module tpsp_sine_rom #(
    parameter int unsigned DEPTH = tpsp_pkg::SINE_ROM_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic [$clog2(DEPTH)+1:0]         idx,
    output logic signed [15:0]               data
);
    import tpsp_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [14:0]   tbl [0:DEPTH];
    logic [1:0]    quad;
    logic [AW-1:0] frac;
    logic [AW:0]   addr;
    logic [14:0]   mag;

    // constant table, one entry past the quarter
    for (genvar g = 0; g <= DEPTH; g++)
    begin : g_tbl
        assign tbl[g] = sine_entry(g, AW);
    end

    // fold the full turn onto the quarter wave
    assign quad = idx[AW+1:AW];
    assign frac = idx[AW-1:0];
    assign addr = quad[0] ? ((AW+1)'(DEPTH) - {1'b0, frac}) : {1'b0, frac};
    assign mag  = tbl[addr];

    // registered read with sign of the lower half turn
    always_ff @(posedge clk)
    begin
        if (quad[1])
            data <= -$signed({1'b0, mag});
        else
            data <= $signed({1'b0, mag});
    end

endmodule

@@ rtl/tpsp_mul.sv @@
// ----------------------------------------------------------------------------
// tpsp_mul
// Shared signed 17x17 multiplier with a registered product.
// ----------------------------------------------------------------------------
module tpsp_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [16:0] a,
    input  logic signed [16:0] b,
    output logic signed [33:0] prod
);
    import tpsp_pkg::*;

    logic signed [33:0] prod_reg;
    logic signed [33:0] prod_next;

    // product, held while idle
    assign prod_next = en ? (a * b) : prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/tpsp_phase_drive.sv @@
// ----------------------------------------------------------------------------
// tpsp_phase_drive
// Turns a phase voltage product into drive mode and clamped duty ratio.
// ----------------------------------------------------------------------------
module tpsp_phase_drive (
    input  logic signed [33:0] prod,
    input  logic               negate,
    input  logic               supply_ok,
    input  logic [14:0]        duty_cap,
    input  logic [14:0]        deadband,
    output tpsp_pkg::drive_t   drive
);
    import tpsp_pkg::*;

    logic [33:0] mag;
    logic [15:0] ratio_raw;
    logic [14:0] ratio;
    logic        fwd;

    // magnitude and direction of the voltage
    assign mag = prod[33] ? 34'(-prod) : 34'(prod);
    assign fwd = negate ? (prod <= 0) : (prod >= 0);

    // q2.30 to q1.15, clamp to the duty limit
    assign ratio_raw = supply_ok ? mag[30:15] : 16'd0;
    assign ratio     = (ratio_raw > {1'b0, duty_cap}) ? duty_cap : ratio_raw[14:0];

    // deadband test
    always_comb
    begin
        if (ratio < deadband)
        begin
            drive.mode  = MODE_OFF;
            drive.ratio = 15'd0;
        end
        else
        begin
            drive.mode  = fwd ? MODE_FWD : MODE_REV;
            drive.ratio = ratio;
        end
    end

endmodule

@@ bench/two_phase_open_loop_sine_pwm_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_phase_open_loop_sine_pwm_tb
// Self-checking bench for the two-phase sine commutator. Every accepted
// request word updates a local copy of angle and amplitude, register writes
// update the register copy, and each tick or set-angle word queues the expected
// drive word. Drive words from the block are checked against that queue in
// order. A directed opening covers field extremes and the corner cases. Random
// phases over several register settings and handshake idling patterns follow.
// ----------------------------------------------------------------------------

// quarter-wave table size, matches the block default
localparam int unsigned QUARTER_STEPS = 256;
// pi/2 in Q30 for the table series
localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

class drive_checker;

    int unsigned quarter_wave[QUARTER_STEPS+1];

    // commutation state
    logic [15:0] elec_angle;
    int          amp_q15;

    // register copy
    logic [15:0] phase_step;
    logic [14:0] duty_cap;
    logic [14:0] deadband;
    logic [15:0] period_a;
    logic [15:0] period_b;
    logic        supply_ok;

    tpsp_pkg::rsp_word_t expected_drive[$];
    int errors;

    function new();
        for (int unsigned i = 0; i <= QUARTER_STEPS; i++)
            quarter_wave[i] = quarter_sine(i);
        elec_angle = '0;
        amp_q15    = 0;
        phase_step = tpsp_pkg::PHASE_STEP_RST;
        duty_cap   = tpsp_pkg::DUTY_CAP_RST;
        deadband   = tpsp_pkg::DEADBAND_RST;
        period_a   = tpsp_pkg::PERIOD_RST;
        period_b   = tpsp_pkg::PERIOD_RST;
        supply_ok  = 1'b0;
        errors     = 0;
    endfunction

    // taylor series in Q30, rounded to 32767 full scale
    function int unsigned quarter_sine(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        x    = (PI_HALF_Q30 * i) / QUARTER_STEPS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int unsigned k = 1; k <= 10; k++)
        begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return int'((acc * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    // full-wave sine from the quarter table
    function int signed_sine(input int unsigned idx);
        int unsigned quadrant;
        int unsigned offset;
        idx      = idx % (4 * QUARTER_STEPS);
        quadrant = idx / QUARTER_STEPS;
        offset   = idx % QUARTER_STEPS;
        case (quadrant)
            0:       return int'(quarter_wave[offset]);
            1:       return int'(quarter_wave[QUARTER_STEPS - offset]);
            2:       return -int'(quarter_wave[offset]);
            default: return -int'(quarter_wave[QUARTER_STEPS - offset]);
        endcase
    endfunction

    // one phase: deadband, direction, compare value
    function void drive_phase(input int volts, input logic [15:0] period,
                              output logic [1:0] mode, output logic [15:0] duty);
        int unsigned mag;
        int unsigned ratio;
        int unsigned cnt;
        mag   = (volts >= 0) ? volts : -volts;
        ratio = supply_ok ? (mag >> 15) : 0;
        if (ratio > duty_cap)
            ratio = duty_cap;
        if (ratio < deadband)
        begin
            mode = tpsp_pkg::MODE_OFF;
            duty = '0;
            return;
        end
        cnt = (ratio * period) >> 15;
        if (cnt > period)
            cnt = period;
        mode = (volts >= 0) ? tpsp_pkg::MODE_FWD : tpsp_pkg::MODE_REV;
        duty = cnt[15:0];
    endfunction

    function void set_reg(input logic [tpsp_pkg::CFG_INDEX_W-1:0] index,
                          input logic [15:0] data);
        case (index)
            tpsp_pkg::CFG_PHASE_STEP: phase_step = data;
            tpsp_pkg::CFG_DUTY_CAP:   duty_cap   = data[14:0];
            tpsp_pkg::CFG_DEADBAND:   deadband   = data[14:0];
            tpsp_pkg::CFG_PERIOD_A:   period_a   = data;
            tpsp_pkg::CFG_PERIOD_B:   period_b   = data;
            tpsp_pkg::CFG_SUPPLY_OK:  supply_ok  = data[0];
            default: ;
        endcase
    endfunction

    // accepted request word: update state, queue drive word if one is due
    function void note_request(input tpsp_pkg::req_word_t w);
        int target;
        int cur;
        int sin_v;
        int cos_v;
        int unsigned idx;
        tpsp_pkg::rsp_word_t drv;
        target = int'(w.amp_goal);
        if (target > duty_cap)
            target = duty_cap;
        case (w.req_type)
            tpsp_pkg::REQ_RAMP:
            begin
                cur = supply_ok ? amp_q15 : 0;
                if (cur < target)
                begin
                    cur = cur + int'(w.ramp_step);
                    if (cur > target)
                        cur = target;
                end
                else if (cur > target)
                begin
                    cur = cur - int'(w.ramp_step);
                    if (cur < target)
                        cur = target;
                end
                amp_q15 = cur;
            end
            tpsp_pkg::REQ_SET_RATIO:
                amp_q15 = target;
            default:
            begin
                if (w.req_type == tpsp_pkg::REQ_TICK)
                    elec_angle = elec_angle + phase_step;
                else
                begin
                    elec_angle = w.angle;
                    amp_q15    = int'($signed(w.amplitude));
                end
                idx   = (32'(elec_angle) * 4 * QUARTER_STEPS) >> 16;
                sin_v = signed_sine(idx);
                cos_v = signed_sine(idx + QUARTER_STEPS);
                drive_phase(-(sin_v * amp_q15), period_a, drv.mode_a, drv.duty_a);
                drive_phase(cos_v * amp_q15, period_b, drv.mode_b, drv.duty_b);
                drv.angle_now = elec_angle;
                expected_drive.push_back(drv);
            end
        endcase
    endfunction

    function void compare(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_drive(input tpsp_pkg::rsp_word_t got);
        tpsp_pkg::rsp_word_t want;
        if (expected_drive.size() == 0)
        begin
            errors++;
            $display("%0t: drive word expected none, got %h", $time, got);
            return;
        end
        want = expected_drive.pop_front();
        compare("mode_a", want.mode_a, got.mode_a);
        compare("duty_a", want.duty_a, got.duty_a);
        compare("mode_b", want.mode_b, got.mode_b);
        compare("duty_b", want.duty_b, got.duty_b);
        compare("angle_now", want.angle_now, got.angle_now);
    endfunction

    function int pending();
        return expected_drive.size();
    endfunction

endclass

module two_phase_open_loop_sine_pwm_tb;

    import tpsp_pkg::*;

    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int unsigned PHASE_WORDS = 138;
    localparam int unsigned PHASES      = 8;

    // indexes past the register list, ignored by the block
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_SUPPLY_OK + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_word_t              req_word  = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_word_t              rsp_word;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int          send_idle = 0;
    int          recv_stall = 0;
    int unsigned cycles = 0;

    drive_checker sb;

    two_phase_open_loop_sine_pwm u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall);
    end

    // watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_word);
            if (rsp_valid && !rsp_stall)
                sb.check_drive(rsp_word);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one word, with a random idle gap before it
    task automatic send_word(input req_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // all drive words back, then let ramp or ratio words settle
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic req_word_t pack_request(input logic [1:0] kind, input logic [15:0] ang,
                                               input logic [15:0] amp, input logic [14:0] tgt,
                                               input logic [14:0] stp);
        req_word_t w;
        w.req_type  = kind;
        w.angle     = ang;
        w.amplitude = amp;
        w.amp_goal  = tgt;
        w.ramp_step = stp;
        return w;
    endfunction

    function automatic req_word_t random_request();
        req_word_t w;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            w.req_type = REQ_TICK;
        else if (pick < 65)
            w.req_type = REQ_SET_ANGLE;
        else if (pick < 90)
            w.req_type = REQ_RAMP;
        else
            w.req_type = REQ_SET_RATIO;
        w.angle = 16'($urandom);
        // small amplitudes now and then so the deadband matters
        if ($urandom_range(3) == 0)
            w.amplitude = 16'($urandom_range(4000)) - 16'd2000;
        else
            w.amplitude = 16'($urandom);
        w.amp_goal = 15'($urandom);
        if ($urandom_range(1) == 0)
            w.ramp_step = 15'($urandom_range(3000));
        else
            w.ramp_step = 15'($urandom);
        return w;
    endfunction

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults, supply low: active modes with zero duty
        send_word(pack_request(REQ_TICK, 16'h1234, 16'h0005, 15'd0, 15'd0));
        send_word(pack_request(REQ_SET_ANGLE, 16'h0000, 16'h7FFF, 15'd0, 15'd0));
        wait_idle();

        // supply up, spare indexes must not disturb anything
        write_reg(CFG_SUPPLY_OK, 16'd1);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        send_word(pack_request(REQ_TICK, 16'h0000, 16'h0000, 15'd0, 15'd0));
        send_word(pack_request(REQ_SET_ANGLE, 16'h0000, 16'h7FFF, 15'd0, 15'd0));
        send_word(pack_request(REQ_SET_ANGLE, 16'h4000, 16'h8000, 15'h7FFF, 15'h7FFF));
        send_word(pack_request(REQ_SET_ANGLE, 16'hFFFF, 16'hFFFF, 15'd0, 15'd0));
        send_word(pack_request(REQ_SET_ANGLE, 16'h8000, 16'h7FFF, 15'd0, 15'd0));
        send_word(pack_request(REQ_SET_ANGLE, 16'hC000, 16'h4000, 15'd0, 15'd0));
        // ratio above the duty cap gets clamped
        send_word(pack_request(REQ_SET_RATIO, 16'h0000, 16'h0000, 15'h7FFF, 15'd0));
        send_word(pack_request(REQ_TICK, 16'h0000, 16'h0000, 15'd0, 15'd0));
        // ramp down past target, a partial step up, and a zero step
        send_word(pack_request(REQ_RAMP, 16'h0000, 16'h0000, 15'd0, 15'h7FFF));
        send_word(pack_request(REQ_RAMP, 16'h0000, 16'h0000, 15'h7FFF, 15'd1000));
        send_word(pack_request(REQ_RAMP, 16'h0000, 16'h0000, 15'd10000, 15'd0));
        send_word(pack_request(REQ_TICK, 16'h0000, 16'h0000, 15'd0, 15'd0));
        wait_idle();

        // supply low with a deadband, period of one and of zero
        write_reg(CFG_SUPPLY_OK, 16'd0);
        write_reg(CFG_DEADBAND, 16'd100);
        write_reg(CFG_PHASE_STEP, 16'hFFFF);
        write_reg(CFG_DUTY_CAP, 16'd32767);
        write_reg(CFG_PERIOD_A, 16'd1);
        write_reg(CFG_PERIOD_B, 16'd0);
        send_word(pack_request(REQ_RAMP, 16'h0000, 16'h0000, 15'd5000, 15'd3000));
        send_word(pack_request(REQ_SET_ANGLE, 16'h2000, 16'h8000, 15'd0, 15'd0));
        send_word(pack_request(REQ_TICK, 16'h0000, 16'h0000, 15'd0, 15'd0));
        wait_idle();

        // full-scale deadband: only the largest ratio gets through
        write_reg(CFG_SUPPLY_OK, 16'd1);
        write_reg(CFG_DEADBAND, 16'd32767);
        write_reg(CFG_PERIOD_A, 16'hFFFF);
        write_reg(CFG_PERIOD_B, 16'd1);
        send_word(pack_request(REQ_SET_ANGLE, 16'h0000, 16'h8000, 15'h7FFF, 15'h7FFF));
        send_word(pack_request(REQ_TICK, 16'hFFFF, 16'h7FFF, 15'h7FFF, 15'h7FFF));
        send_word(pack_request(REQ_SET_RATIO, 16'hFFFF, 16'hFFFF, 15'd0, 15'h7FFF));
        send_word(pack_request(REQ_TICK, 16'h0000, 16'h0000, 15'd0, 15'd0));
        wait_idle();

        // random phases over register settings and idling patterns
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_PHASE_STEP, (p == 0) ? 16'hFFFF : 16'($urandom));
            write_reg(CFG_DUTY_CAP, (p == 1) ? 16'd0 :
                                    (p == 2 || p == 3) ? 16'd32767 :
                                    16'($urandom_range(32767, 16384)));
            write_reg(CFG_DEADBAND, (p == 3) ? 16'd32767 :
                                    (p == 5 || p == 6) ? 16'($urandom_range(3000)) : 16'd0);
            write_reg(CFG_PERIOD_A, (p == 2) ? 16'hFFFF : (p == 4) ? 16'd1 :
                                    16'($urandom_range(65535, 1)));
            write_reg(CFG_PERIOD_B, (p == 2) ? 16'hFFFF : (p == 4) ? 16'd0 :
                                    16'($urandom_range(65535, 1)));
            write_reg(CFG_SUPPLY_OK, (p == 6) ? 16'd0 : 16'd1);
            case (p % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 48; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 23; recv_stall = 23; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_request());
            wait_idle();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
